// ----- design/lte_pkg.sv -----
// ----------------------------------------------------------------------------
// lte_pkg: shared types and constants of the linear tween engine
// Command codes, result kinds, register indexes and the queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package lte_pkg;

   localparam int FIFO_DEPTH = 2;

   // Function codes of the request channel.
   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_ORIGIN = 3'd1;
   localparam logic [2:0] FUNC_START  = 3'd2;
   localparam logic [2:0] FUNC_PAUSE  = 3'd3;
   localparam logic [2:0] FUNC_RESUME = 3'd4;
   localparam logic [2:0] FUNC_STOP   = 3'd5;
   localparam logic [2:0] FUNC_FINISH = 3'd6;

   // Register indexes of the control port.
   localparam logic [1:0] CSR_DURATION = 2'd0;
   localparam logic [1:0] CSR_SCALE    = 2'd1;
   localparam logic [1:0] CSR_LOOP     = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_STARTED = 2'd0;
   localparam logic [1:0] KIND_FRAME   = 2'd1;
   localparam logic [1:0] KIND_LOOPED  = 2'd2;
   localparam logic [1:0] KIND_ENDED   = 2'd3;

   localparam logic [23:0] DURATION_RESET = 24'd0;
   localparam logic [15:0] SCALE_RESET    = 16'd256;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_ORIGIN,
      OP_START,
      OP_PAUSE,
      OP_RESUME,
      OP_STOP,
      OP_FINISH,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [23:0] duration_time;
      logic [15:0] time_scale;
      logic        loop_enable;
   } cfg_type;

   typedef struct packed {
      op_type          op;
      logic [3:0][15:0] rect;
      logic            alpha_neg;
      logic [15:0]     alpha;
      logic [15:0]     frame_time;
      logic            target_active;
   } entry_type;

endpackage

`default_nettype wire

// ----- design/lte_front.sv -----
// ----------------------------------------------------------------------------
// lte_front: request decode and command queue
// Accepts requests, classifies the function code and queues the commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lte_front #(
   parameter int Depth = lte_pkg::FIFO_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [2:0]         req_func,
   input  wire logic [15:0]        req_rect_x,
   input  wire logic [15:0]        req_rect_y,
   input  wire logic [15:0]        req_rect_w,
   input  wire logic [15:0]        req_rect_h,
   input  wire logic [16:0]        req_alpha_value,
   input  wire logic [15:0]        req_frame_time,
   input  wire logic               req_target_active,
   output      logic               q_valid,
   output      lte_pkg::entry_type q_data,
   input  wire logic               q_pop
);
   import lte_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   entry_type       mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   entry_type       entry_in;
   logic            push;

   always_comb begin
      entry_in.rect          = {req_rect_h, req_rect_w, req_rect_y, req_rect_x};
      entry_in.alpha_neg     = req_alpha_value[16];
      entry_in.alpha         = req_alpha_value[15:0];
      entry_in.frame_time    = req_frame_time;
      entry_in.target_active = req_target_active;
      unique case (req_func)
         FUNC_TICK:   entry_in.op = OP_TICK;
         FUNC_ORIGIN: entry_in.op = OP_ORIGIN;
         FUNC_START:  entry_in.op = OP_START;
         FUNC_PAUSE:  entry_in.op = OP_PAUSE;
         FUNC_RESUME: entry_in.op = OP_RESUME;
         FUNC_STOP:   entry_in.op = OP_STOP;
         FUNC_FINISH: entry_in.op = OP_FINISH;
         default:     entry_in.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff != FullCnt);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_data    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !q_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (q_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // The queue never holds more than its depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("command queue overfilled");

   // A pop never meets an empty queue.
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty command queue");

   // A push never lands in a full queue.
   a_push_notfull : assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != FullCnt)
      else $error("push into full command queue");

endmodule

`default_nettype wire

// ----- design/lte_back.sv -----
// ----------------------------------------------------------------------------
// lte_back: tween state and arithmetic
// Executes queued commands: state updates, serial division and shared lerp.
// ----------------------------------------------------------------------------
`default_nettype none

module lte_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lte_pkg::cfg_type   cfg,
   input  wire logic               q_valid,
   input  wire lte_pkg::entry_type q_data,
   output      logic               q_pop,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [1:0]         rsp_kind,
   output      logic [16:0]        rsp_progress,
   output      logic [15:0]        rsp_out_x,
   output      logic [15:0]        rsp_out_y,
   output      logic [15:0]        rsp_out_w,
   output      logic [15:0]        rsp_out_h,
   output      logic [15:0]        rsp_out_alpha
);
   import lte_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ACC, S_CMP, S_DIV, S_MUL, S_ADD, S_OUT
   } state_type;

   state_type        state_ff;
   logic [31:0]      pos_ff;
   logic             playing_ff, paused_ff, ticking_ff, target_ff;
   logic [3:0][15:0] org_rect_ff, goal_rect_ff;
   logic [15:0]      org_alpha_ff, goal_alpha_ff;
   logic [23:0]      run_dur_ff;
   logic [15:0]      ftime_ff;
   logic [23:0]      rem_ff;
   logic [15:0]      lo_ff;
   logic [15:0]      quo_ff;
   logic [3:0]       cnt_ff;
   logic [2:0]       lane_ff;
   logic signed [33:0] prod_ff;
   logic [1:0]       res_kind_ff;
   logic [16:0]      res_prog_ff;
   logic [4:0][15:0] res_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_kind_ff;
   logic [16:0]      rsp_prog_ff;
   logic [4:0][15:0] rsp_ff;

   logic [31:0]        scaled;
   logic [32:0]        acc_sum;
   logic [31:0]        lim;
   logic [24:0]        trial;
   logic [24:0]        trial_sub;
   logic               fits;
   logic [15:0]        lane_a, lane_b;
   logic signed [16:0] mix_diff;
   logic signed [16:0] mix_p;
   logic signed [33:0] mix_prod;
   logic signed [33:0] mix_sum;
   logic               same;

   assign scaled    = ftime_ff * cfg.time_scale;
   assign acc_sum   = {1'b0, pos_ff} + {1'b0, scaled};
   assign lim       = {run_dur_ff, 8'h00};
   assign trial     = {rem_ff, lo_ff[15]};
   assign fits      = (trial >= {1'b0, run_dur_ff});
   assign trial_sub = trial - {1'b0, run_dur_ff};

   // Rectangle lanes are offset to unsigned before mixing.
   always_comb begin
      if (lane_ff[2]) begin
         lane_a = org_alpha_ff;
         lane_b = goal_alpha_ff;
      end else begin
         lane_a = org_rect_ff[lane_ff[1:0]] ^ 16'h8000;
         lane_b = goal_rect_ff[lane_ff[1:0]] ^ 16'h8000;
      end
   end

   assign mix_diff = $signed({1'b0, lane_b}) - $signed({1'b0, lane_a});
   assign mix_p    = $signed({1'b0, quo_ff});
   assign mix_prod = mix_diff * mix_p;
   assign mix_sum  = $signed({2'b00, lane_a, 16'h0000}) + prod_ff + 34'sd32768;

   assign same = !q_data.alpha_neg && (q_data.alpha == org_alpha_ff)
                 && (q_data.rect == org_rect_ff);

   assign q_pop         = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_progress  = rsp_prog_ff;
   assign rsp_out_x     = rsp_ff[0];
   assign rsp_out_y     = rsp_ff[1];
   assign rsp_out_w     = rsp_ff[2];
   assign rsp_out_h     = rsp_ff[3];
   assign rsp_out_alpha = rsp_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pos_ff        <= '0;
         playing_ff    <= 1'b0;
         paused_ff     <= 1'b0;
         ticking_ff    <= 1'b0;
         target_ff     <= 1'b0;
         org_rect_ff   <= '0;
         goal_rect_ff  <= '0;
         org_alpha_ff  <= '0;
         goal_alpha_ff <= '0;
         run_dur_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // In the output state the register is reloaded below instead.
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  unique case (q_data.op)
                     OP_TICK: begin
                        ftime_ff <= q_data.frame_time;
                        if (ticking_ff && playing_ff && target_ff
                            && q_data.target_active) begin
                           state_ff <= S_ACC;
                        end
                     end
                     OP_ORIGIN: begin
                        org_rect_ff  <= q_data.rect;
                        org_alpha_ff <= q_data.alpha_neg ? 16'h0000 : q_data.alpha;
                     end
                     OP_START: begin
                        if (!same) begin
                           // A start while playing halts first, which clears pause.
                           if (playing_ff || !paused_ff) begin
                              pos_ff        <= '0;
                              run_dur_ff    <= cfg.duration_time;
                              goal_rect_ff  <= q_data.rect;
                              goal_alpha_ff <= q_data.alpha_neg ? org_alpha_ff
                                                                : q_data.alpha;
                              target_ff     <= 1'b1;
                           end
                           paused_ff   <= 1'b0;
                           playing_ff  <= 1'b1;
                           ticking_ff  <= 1'b1;
                           res_kind_ff <= KIND_STARTED;
                           res_prog_ff <= '0;
                           res_ff      <= {org_alpha_ff, org_rect_ff};
                           state_ff    <= S_OUT;
                        end
                     end
                     OP_PAUSE: begin
                        paused_ff  <= 1'b1;
                        ticking_ff <= 1'b0;
                     end
                     OP_RESUME: begin
                        if (target_ff) begin
                           paused_ff  <= 1'b0;
                           playing_ff <= 1'b1;
                           ticking_ff <= 1'b1;
                        end
                     end
                     OP_STOP: begin
                        playing_ff <= 1'b0;
                        paused_ff  <= 1'b0;
                        ticking_ff <= 1'b0;
                        target_ff  <= 1'b0;
                     end
                     OP_FINISH: begin
                        pos_ff <= lim;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_ACC: begin
               pos_ff   <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (pos_ff >= lim) begin
                  res_kind_ff <= cfg.loop_enable ? KIND_LOOPED : KIND_ENDED;
                  res_prog_ff <= 17'h10000;
                  res_ff      <= {goal_alpha_ff, goal_rect_ff};
                  if (cfg.loop_enable) begin
                     pos_ff        <= pos_ff - lim;
                     org_rect_ff   <= goal_rect_ff;
                     goal_rect_ff  <= org_rect_ff;
                     org_alpha_ff  <= goal_alpha_ff;
                     goal_alpha_ff <= org_alpha_ff;
                  end else begin
                     playing_ff <= 1'b0;
                     paused_ff  <= 1'b0;
                     ticking_ff <= 1'b0;
                     target_ff  <= 1'b0;
                  end
                  state_ff <= S_OUT;
               end else begin
                  // The quotient fits 16 bits, so the top of the dividend starts
                  // as the partial remainder.
                  rem_ff   <= pos_ff[31:8];
                  lo_ff    <= {pos_ff[7:0], 8'h00};
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= fits ? trial_sub[23:0] : trial[23:0];
               quo_ff <= {quo_ff[14:0], fits};
               lo_ff  <= {lo_ff[14:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 4'hF) begin
                  lane_ff  <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= mix_prod;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               res_ff[lane_ff] <= lane_ff[2] ? mix_sum[31:16]
                                             : (mix_sum[31:16] ^ 16'h8000);
               if (lane_ff == 3'd4) begin
                  res_kind_ff <= KIND_FRAME;
                  res_prog_ff <= {1'b0, quo_ff};
                  state_ff    <= S_OUT;
               end else begin
                  lane_ff  <= lane_ff + 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= res_kind_ff;
                  rsp_prog_ff  <= res_prog_ff;
                  rsp_ff       <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // The divider only runs with a non-zero duration.
   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> run_dur_ff != '0)
      else $error("division started with zero duration");

   // A running frame never reaches full progress.
   a_frame_progress : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_FRAME |-> !rsp_prog_ff[16])
      else $error("frame result with full progress");

   // A final result always carries full progress.
   a_final_progress : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_LOOPED || rsp_kind_ff == KIND_ENDED)
      |-> rsp_prog_ff == 17'h10000)
      else $error("final result without full progress");

endmodule

`default_nettype wire

// ----- design/linear_tween_engine.sv -----
// ----------------------------------------------------------------------------
// linear_tween_engine: linear rectangle and alpha tween
// Steps a position accumulator per tick and emits interpolated frames.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_valid / req_ready  function code, rectangle, alpha, time
//   rsp_     out        rsp_valid / rsp_ready  result kind, progress, rectangle, alpha
//   csr_     in         csr_valid / csr_ready  register index and write data
//
// A control command is handled in the idle state of the back end; one that
// produces a result then passes through the output state to the output register.
// A tick that ends the run passes the accumulate, compare and output states;
// a tick that yields a frame also runs the sixteen-step restoring divider for
// progress and the single shared multiplier, with a multiply and an add state per lane.
// Reset is synchronous and returns the control registers, queue and tween state to their reset values.
// The request side keeps accepting into its queue while the back end stalls on
// a result that has not yet been taken.
`default_nettype none

module linear_tween_engine #(
   parameter int FifoDepth = lte_pkg::FIFO_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_func,
   input  wire logic [15:0] req_rect_x,
   input  wire logic [15:0] req_rect_y,
   input  wire logic [15:0] req_rect_w,
   input  wire logic [15:0] req_rect_h,
   input  wire logic [16:0] req_alpha_value,
   input  wire logic [15:0] req_frame_time,
   input  wire logic        req_target_active,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_kind,
   output      logic [16:0] rsp_progress,
   output      logic [15:0] rsp_out_x,
   output      logic [15:0] rsp_out_y,
   output      logic [15:0] rsp_out_w,
   output      logic [15:0] rsp_out_h,
   output      logic [15:0] rsp_out_alpha,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);
   import lte_pkg::*;

   cfg_type   cfg_ff;
   logic      q_valid;
   logic      q_pop;
   entry_type q_data;

   // Register writes are always taken; writes to an unused index fall away.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duration_time <= DURATION_RESET;
         cfg_ff.time_scale    <= SCALE_RESET;
         cfg_ff.loop_enable   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DURATION: cfg_ff.duration_time <= csr_wdata;
            CSR_SCALE:    cfg_ff.time_scale    <= csr_wdata[15:0];
            CSR_LOOP:     cfg_ff.loop_enable   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // The front end decodes requests into a short queue so that a slow frame
   // computation blocks the request channel only once the queue is full.
   lte_front #(
      .Depth (FifoDepth)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .req_alpha_value   (req_alpha_value),
      .req_frame_time    (req_frame_time),
      .req_target_active (req_target_active),
      .q_valid           (q_valid),
      .q_data            (q_data),
      .q_pop             (q_pop)
   );

   // The back end owns all tween state and the result register.
   lte_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_progress  (rsp_progress),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_w     (rsp_out_w),
      .rsp_out_h     (rsp_out_h),
      .rsp_out_alpha (rsp_out_alpha)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb_linear_tween_engine.sv -----
// ----------------------------------------------------------------------------
// tb_linear_tween_engine: self-checking bench for the linear tween engine
// Drives commands and ticks with random idling and a long output hold-off,
// predicts every result in a scoreboard model and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class tween_scoreboard;
   // Register copies.
   bit [23:0] cfg_duration;
   bit [15:0] cfg_scale;
   bit        cfg_loop;
   // Tween state.
   bit [31:0] pos_acc;
   bit        playing, paused, ticking, has_goal;
   bit signed [15:0] org_rect [4];
   bit signed [15:0] dst_rect [4];
   bit [15:0] org_alpha, dst_alpha;
   bit [23:0] run_len;
   // Expected results: kind, progress, x, y, w, h, alpha packed together.
   bit [112:0] frames_due [$];
   int         errors;

   function new();
      errors = 0;
      cfg_duration = 0;
      cfg_scale = 256;
      cfg_loop = 0;
      pos_acc = 0;
      halt();
      for (int i = 0; i < 4; i++) begin
         org_rect[i] = 0;
         dst_rect[i] = 0;
      end
      org_alpha = 0;
      dst_alpha = 0;
      run_len = 0;
   endfunction

   function void halt();
      playing = 0;
      paused = 0;
      ticking = 0;
      has_goal = 0;
   endfunction

   function void write_reg(bit [1:0] idx, bit [23:0] val);
      if (idx == lte_pkg::CSR_DURATION) cfg_duration = val;
      else if (idx == lte_pkg::CSR_SCALE) cfg_scale = val[15:0];
      else if (idx == lte_pkg::CSR_LOOP) cfg_loop = val[0];
   endfunction

   // Weighted blend of two lanes, rounded half up; signed lanes are offset.
   function bit [15:0] blend(bit [15:0] s, bit [15:0] e, bit [16:0] p, bit sgn);
      bit [63:0] a, b, u;
      a = sgn ? {48'd0, s ^ 16'h8000} : {48'd0, s};
      b = sgn ? {48'd0, e ^ 16'h8000} : {48'd0, e};
      u = (a * (64'd65536 - p) + b * p + 64'd32768) >> 16;
      return sgn ? (u[15:0] ^ 16'h8000) : u[15:0];
   endfunction

   // The layout matches the sampled result, with the same low padding.
   function void push(bit [1:0] k, bit [16:0] p, bit [15:0] r [4], bit [15:0] a);
      frames_due.push_back({k, p, r[0], r[1], r[2], r[3], a, 14'd0});
   endfunction

   // Note one accepted request and queue what it should produce.
   function void note_request(bit [2:0] fn, bit [15:0] rr [4], bit [16:0] av,
                              bit [15:0] ft, bit act);
      bit [15:0] r [4];
      bit [63:0] sum, p;
      bit [31:0] lim;
      bit        same;
      bit signed [16:0] sa;
      sa = av;
      case (fn)
         lte_pkg::FUNC_TICK: begin
            if (!(ticking && playing && has_goal) || !act) return;
            sum = {32'd0, pos_acc} + {48'd0, ft} * cfg_scale;
            pos_acc = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            lim = {run_len, 8'd0};
            if (pos_acc >= lim) begin
               for (int i = 0; i < 4; i++) r[i] = dst_rect[i];
               push(cfg_loop ? lte_pkg::KIND_LOOPED : lte_pkg::KIND_ENDED,
                    17'd65536, r, dst_alpha);
               if (cfg_loop) begin
                  pos_acc -= lim;
                  for (int i = 0; i < 4; i++) begin
                     r[i] = org_rect[i];
                     org_rect[i] = dst_rect[i];
                     dst_rect[i] = r[i];
                  end
                  {org_alpha, dst_alpha} = {dst_alpha, org_alpha};
               end else begin
                  halt();
               end
            end else begin
               p = ({32'd0, pos_acc} << 8) / run_len;
               if (p > 65535) p = 65535;
               for (int i = 0; i < 4; i++) r[i] = blend(org_rect[i], dst_rect[i], p, 1);
               push(lte_pkg::KIND_FRAME, p[16:0], r, blend(org_alpha, dst_alpha, p, 0));
            end
         end
         lte_pkg::FUNC_ORIGIN: begin
            for (int i = 0; i < 4; i++) org_rect[i] = rr[i];
            org_alpha = (sa < 0) ? 16'd0 : av[15:0];
         end
         lte_pkg::FUNC_START: begin
            same = (sa >= 0) && (av[15:0] == org_alpha);
            for (int i = 0; i < 4; i++) if (rr[i] != org_rect[i]) same = 0;
            if (same) return;
            if (playing) halt();
            if (!paused) begin
               pos_acc = 0;
               run_len = cfg_duration;
               for (int i = 0; i < 4; i++) dst_rect[i] = rr[i];
               dst_alpha = (sa < 0) ? org_alpha : av[15:0];
               has_goal = 1;
            end
            paused = 0;
            playing = 1;
            ticking = 1;
            for (int i = 0; i < 4; i++) r[i] = org_rect[i];
            push(lte_pkg::KIND_STARTED, 17'd0, r, org_alpha);
         end
         lte_pkg::FUNC_PAUSE: begin
            paused = 1;
            ticking = 0;
         end
         lte_pkg::FUNC_RESUME: begin
            if (has_goal) begin
               paused = 0;
               playing = 1;
               ticking = 1;
            end
         end
         lte_pkg::FUNC_STOP: halt();
         lte_pkg::FUNC_FINISH: pos_acc = {run_len, 8'd0};
         default: ;
      endcase
   endfunction

   // Compare one result with the oldest expectation.
   function void check_frame(bit [112:0] got);
      bit [112:0] exp_v;
      if (frames_due.size() == 0) begin
         $error("unexpected result %h", got);
         errors++;
         return;
      end
      exp_v = frames_due.pop_front();
      if (got[112:111] != exp_v[112:111]) begin
         $error("kind exp %0d got %0d", exp_v[112:111], got[112:111]); errors++;
      end
      if (got[110:94] != exp_v[110:94]) begin
         $error("progress exp %0d got %0d", exp_v[110:94], got[110:94]); errors++;
      end
      if (got[93:78] != exp_v[93:78]) begin
         $error("out_x exp %h got %h", exp_v[93:78], got[93:78]); errors++;
      end
      if (got[77:62] != exp_v[77:62]) begin
         $error("out_y exp %h got %h", exp_v[77:62], got[77:62]); errors++;
      end
      if (got[61:46] != exp_v[61:46]) begin
         $error("out_w exp %h got %h", exp_v[61:46], got[61:46]); errors++;
      end
      if (got[45:30] != exp_v[45:30]) begin
         $error("out_h exp %h got %h", exp_v[45:30], got[45:30]); errors++;
      end
      if (got[29:14] != exp_v[29:14]) begin
         $error("out_alpha exp %h got %h", exp_v[29:14], got[29:14]); errors++;
      end
   endfunction
endclass

module tb_linear_tween_engine;
   import lte_pkg::*;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [2:0]  req_func;
   logic [15:0] req_rect_x, req_rect_y, req_rect_w, req_rect_h;
   logic [16:0] req_alpha_value;
   logic [15:0] req_frame_time;
   logic        req_target_active;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_kind;
   logic [16:0] rsp_progress;
   logic [15:0] rsp_out_x, rsp_out_y, rsp_out_w, rsp_out_h, rsp_out_alpha;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   tween_scoreboard sb;
   // Idling controls: quiet_mode switches off all random gaps near the end,
   // and hold_off makes the receiver sit on its ready for a long stretch.
   bit          quiet_mode;
   bit          hold_off;
   longint      cycle_count;

   linear_tween_engine u_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // The watchdog: the slowest correct run is far below this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2_000_000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Every result transfer is sampled at the rising edge and checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_frame({rsp_kind, rsp_progress, rsp_out_x, rsp_out_y, rsp_out_w,
                         rsp_out_h, rsp_out_alpha, 14'd0});
   end

   // The receiver stalls in random bursts, or for a long stretch when asked.
   initial begin
      int gap;
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
   end

   // One request transfer, with an optional random gap ahead of it. Valid is
   // driven with blocking assignments because a transfer may end and the
   // next one begin at the same falling edge.
   task automatic send_req(bit [2:0] fn, bit [15:0] x, bit [15:0] y, bit [15:0] w,
                           bit [15:0] h, bit [16:0] av, bit [15:0] ft, bit act);
      bit [15:0] r [4];
      if (!quiet_mode && $urandom_range(0, 4) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid = 1;
      req_func <= fn;
      req_rect_x <= x;
      req_rect_y <= y;
      req_rect_w <= w;
      req_rect_h <= h;
      req_alpha_value <= av;
      req_frame_time <= ft;
      req_target_active <= act;
      do @(posedge clock); while (!req_ready);
      r = '{x, y, w, h};
      sb.note_request(fn, r, av, ft, act);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic send_cmd(bit [2:0] fn);
      send_req(fn, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic send_tick(bit [15:0] ft, bit act);
      send_req(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, ft, act);
   endtask

   // A start whose target is random, so it almost never equals the origin.
   task automatic send_start(bit [16:0] av);
      send_req(FUNC_START, $urandom, $urandom, $urandom, $urandom, av, $urandom, $urandom);
   endtask

   // Register writes happen only once the block is idle. A request with no
   // result may still be in the back end, so a pause covers its latency.
   task automatic write_csr(bit [1:0] idx, bit [23:0] val);
      while (sb.frames_due.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_alpha(output bit [16:0] av);
      case ($urandom_range(0, 3))
         0: av = 17'h1FFFF;
         1: av = 17'd65535;
         default: av = $urandom_range(0, 65535);
      endcase
   endtask

   // A well-formed animation: set an origin, start, then a run of ticks with the odd
   // pause, resume, finish, stop, unknown code or new start mixed in.
   task automatic animation_run(int n_ticks, int ft_max);
      bit [16:0] av;
      random_alpha(av);
      send_req(FUNC_ORIGIN, $urandom, $urandom, $urandom, $urandom, av, $urandom, $urandom);
      random_alpha(av);
      send_start(av);
      for (int i = 0; i < n_ticks; i++) begin
         case ($urandom_range(0, 39))
            0: send_cmd(FUNC_PAUSE);
            1: send_cmd(FUNC_RESUME);
            2: send_cmd(FUNC_FINISH);
            3: send_cmd(FUNC_STOP);
            4: send_cmd(3'd7);
            5: begin
               random_alpha(av);
               send_start(av);
            end
            default: send_tick($urandom_range(0, ft_max), $urandom_range(0, 9) != 0);
         endcase
      end
   endtask

   initial begin
      int phase;
      sb = new();
      cycle_count = 0;
      quiet_mode = 0;
      hold_off = 0;
      reset = 1;
      req_valid = 0;
      req_func = FUNC_TICK;
      req_rect_x = 0;
      req_rect_y = 0;
      req_rect_w = 0;
      req_rect_h = 0;
      req_alpha_value = 0;
      req_frame_time = 0;
      req_target_active = 0;
      csr_valid = 0;
      csr_index = CSR_DURATION;
      csr_wdata = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed part. A tick before any start gives nothing; with the reset
      // duration of zero every tick ends the run at once.
      send_tick(16'hFFFF, 1);
      send_req(FUNC_START, 0, 0, 0, 0, 0, 0, 1);       // equals origin: ignored
      send_req(FUNC_START, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 17'h1FFFF, 0, 1);
      send_tick(0, 1);
      write_csr(CSR_DURATION, 24'd100);
      write_csr(CSR_SCALE, 16'hFFFF);
      send_req(FUNC_ORIGIN, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 17'h1FFFF, 0, 0);
      send_req(FUNC_START, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 17'd65535, 0, 1);
      send_tick(1, 0);                                  // inactive: no result
      send_tick(1, 1);
      send_cmd(FUNC_PAUSE);
      send_tick(5, 1);                                  // paused: no result
      send_req(FUNC_START, 1, 2, 3, 4, 17'd9, 0, 1);   // still playing: restarts with a new target
      send_tick(40, 1);
      send_cmd(FUNC_FINISH);
      send_tick(0, 1);
      send_cmd(FUNC_RESUME);                            // no target: ignored
      send_cmd(3'd7);
      write_csr(CSR_LOOP, 24'd1);
      write_csr(CSR_DURATION, 24'hFFFFFF);
      send_start(17'd1234);
      send_tick(16'hFFFF, 1);
      send_tick(16'hFFFF, 1);
      send_cmd(FUNC_STOP);
      write_csr(CSR_SCALE, 16'd0);
      send_start(17'd77);
      send_tick(16'hFFFF, 1);

      // Random part in phases, each with its own settings.
      for (phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin
               write_csr(CSR_DURATION, $urandom_range(1, 4000));
               write_csr(CSR_SCALE, 16'd256);
            end
            1: begin
               write_csr(CSR_DURATION, $urandom_range(0, 24'hFFFFFF));
               write_csr(CSR_SCALE, 16'hFFFF);
            end
            2: begin
               write_csr(CSR_DURATION, $urandom_range(0, 3));
               write_csr(CSR_SCALE, $urandom_range(0, 65535));
            end
            default: begin
               write_csr(CSR_DURATION, $urandom_range(1, 600));
               write_csr(CSR_SCALE, $urandom_range(1, 1024));
            end
         endcase
         write_csr(CSR_LOOP, $urandom_range(0, 1));
         // Midway the receiver sits still while requests pile up behind it.
         if (phase == 5) hold_off = 1;
         // The last phase runs without any idling once its registers are set.
         if (phase == 11) quiet_mode = 1;
         for (int k = 0; k < 6; k++)
            animation_run(22, (phase % 4 == 1) ? 65535 : 300);
      end

      while (sb.frames_due.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (sb.errors == 0 && sb.frames_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
